FILE: sv/i2cdf_pkg.sv
// Shared types, symbol codes and framing constants for the two-wire display byte framer.
// Has no dependencies. The interfaces reference it and all modules import it.
package i2cdf_pkg;

	localparam int SYMBOL_W    = 2;
	localparam int BYTE_W      = 8;
	localparam int QUEUE_DEPTH = 2;

	// bus symbol codes
	typedef enum logic [SYMBOL_W-1:0] {
		SYM_START = 2'd0,
		SYM_BIT   = 2'd1,
		SYM_ACK   = 2'd2,
		SYM_STOP  = 2'd3
	} symbol_t;

	localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h78;
	localparam logic [BYTE_W-1:0] CTRL_DATA  = 8'h40;
	localparam logic [BYTE_W-1:0] CTRL_CMD   = 8'h00;

	// one classified transaction, ready for the serialiser
	typedef struct packed {
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] ctrl;
		logic [BYTE_W-1:0] value;
	} entry_t;

	// handshake between two internal stages
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} entry_req_t;

endpackage

FILE: sv/i2cdf_if.sv
// Valid/ready channel interfaces: input byte channel and bus symbol channel.
// Depends on i2cdf_pkg for field widths.
interface i2cdf_in_if;
	logic                        valid;
	logic                        ready;
	logic                        is_data;
	logic [i2cdf_pkg::BYTE_W-1:0] value;

	modport source (output valid, output is_data, output value, input ready);
	modport sink   (input valid, input is_data, input value, output ready);
endinterface

interface i2cdf_out_if;
	logic                          valid;
	logic                          ready;
	logic [i2cdf_pkg::SYMBOL_W-1:0] symbol;
	logic                          level;
	logic                          last;

	modport source (output valid, output symbol, output level, output last, input ready);
	modport sink   (input valid, input symbol, input level, input last, output ready);
endinterface

FILE: sv/i2c_display_byte_framer.sv
// Top level of the two-wire display byte framer: front stage, entry queue, serialiser.
// Depends on i2cdf_pkg, i2cdf_if, i2cdf_front, i2cdf_queue and i2cdf_back.
//
//   channel   dir   payload                 role
//   req       in    is_data, value          one byte per bus transaction
//   bus       out   symbol, level, last     29 bus symbols per transaction
//   cfg_*     in    cfg_wdata               device address byte, write only
//
// Each byte yields 29 symbols, one per cycle while the bus takes them, so the
// sustained byte rate is set by the serialiser's symbol counters. The first symbol
// passes the front stage register, a queue slot and the serialiser's state and output
// registers. Reset clears the queue and the serialiser and loads address 0x78.
// A stalled bus holds the serialiser; the front stage and queue keep taking bytes until the queue is full.
module i2c_display_byte_framer #(
	parameter int QUEUE_DEPTH = i2cdf_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2cdf_pkg::BYTE_W-1:0]  cfg_wdata,
	i2cdf_in_if.sink                      req,
	i2cdf_out_if.source                   bus
);
	import i2cdf_pkg::*;

	entry_req_t push;
	logic       push_ready;
	entry_req_t pop;
	logic       pop_ready;

	// accept and classify
	i2cdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.push       (push),
		.push_ready (push_ready)
	);

	// decouple front and back
	i2cdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	// serialise onto the bus
	i2cdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_ready (pop_ready),
		.bus       (bus)
	);
endmodule

FILE: sv/i2cdf_front.sv
// Front stage: holds the device address register, accepts input bytes and builds entries.
// Depends on i2cdf_pkg and the input channel interface.
module i2cdf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2cdf_pkg::BYTE_W-1:0]  cfg_wdata,
	i2cdf_in_if.sink                      req,
	output i2cdf_pkg::entry_req_t         push,
	input  logic                          push_ready
);
	import i2cdf_pkg::*;

	logic [BYTE_W-1:0] addr_q;
	logic              valid_s1;
	entry_t            entry_s1;

	// accept when the stage is empty or its entry moves on this cycle
	assign req.ready = !valid_s1 || push_ready;

	// hold the device address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (cfg_we) begin
			addr_q <= cfg_wdata;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// classify: pick the control byte and capture the address
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			entry_s1.addr  <= addr_q;
			entry_s1.ctrl  <= req.is_data ? CTRL_DATA : CTRL_CMD;
			entry_s1.value <= req.value;
		end
	end

	assign push.valid = valid_s1;
	assign push.entry = entry_s1;
endmodule

FILE: sv/i2cdf_queue.sv
// Short FIFO of classified entries between the front stage and the serialiser.
// Depends on i2cdf_pkg.
module i2cdf_queue #(
	parameter int DEPTH = i2cdf_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cdf_pkg::entry_req_t push,
	output logic                  push_ready,
	output i2cdf_pkg::entry_req_t pop,
	input  logic                  pop_ready
);
	import i2cdf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t            slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop.valid  = (count_q != '0);
	assign pop.entry  = slots_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	// store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push.entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: sv/i2cdf_back.sv
// Back stage: serialises one entry into start, three bytes with acknowledge clocks, and stop.
// Depends on i2cdf_pkg and the symbol channel interface.
module i2cdf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cdf_pkg::entry_req_t pop,
	output logic                  pop_ready,
	i2cdf_out_if.source           bus
);
	import i2cdf_pkg::*;

	localparam int SHIFT_W = 3 * BYTE_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_BYTES,
		ST_STOP
	} state_t;

	state_t               state_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [3:0]           bit_q;
	logic [1:0]           byte_q;
	logic                 last_bit_q;
	logic                 out_valid_q;
	symbol_t              symbol_q;
	logic                 level_q;
	logic                 last_q;
	logic                 advance;

	// output register frees when empty or taken
	assign advance   = !out_valid_q || bus.ready;
	assign pop_ready = (state_q == ST_IDLE) || (advance && (state_q == ST_STOP));

	assign bus.valid  = out_valid_q;
	assign bus.symbol = symbol_q;
	assign bus.level  = level_q;
	assign bus.last   = last_q;

	// sequence the symbols of one transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (advance) begin
						out_valid_q <= 1'b0;
					end
					if (pop.valid) begin
						shift_q <= {pop.entry.addr, pop.entry.ctrl, pop.entry.value};
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						symbol_q    <= SYM_START;
						level_q     <= 1'b0;
						last_q      <= 1'b0;
						bit_q       <= '0;
						byte_q      <= '0;
						state_q     <= ST_BYTES;
					end
				end
				ST_BYTES: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						last_q      <= 1'b0;
						if (bit_q == 4'd8) begin
							// acknowledge clock: data line stays at the last bit
							symbol_q <= SYM_ACK;
							level_q  <= last_bit_q;
							bit_q    <= '0;
							if (byte_q == 2'd2) begin
								state_q <= ST_STOP;
							end else begin
								byte_q <= byte_q + 1'b1;
							end
						end else begin
							symbol_q   <= SYM_BIT;
							level_q    <= shift_q[SHIFT_W-1];
							last_bit_q <= shift_q[SHIFT_W-1];
							shift_q    <= {shift_q[SHIFT_W-2:0], 1'b0};
							bit_q      <= bit_q + 1'b1;
						end
					end
				end
				ST_STOP: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						symbol_q    <= SYM_STOP;
						level_q     <= 1'b0;
						last_q      <= 1'b1;
						// load the next entry alongside the stop
						if (pop.valid) begin
							shift_q <= {pop.entry.addr, pop.entry.ctrl, pop.entry.value};
							state_q <= ST_START;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
